// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bpl_pkg.sv =====
// ----------------------------------------------------------------------------
// bpl_pkg
// Item types, operation and status codes and cell commands of the list.
// ----------------------------------------------------------------------------
package bpl_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 4;
  localparam int POS_IN_W  = 8;
  localparam int STATUS_W  = 3;
  localparam int POS_OUT_W = 6;
  localparam int CNT_OUT_W = 6;

  localparam logic [OP_W-1:0] OP_INS_HEAD = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 4'd1;
  localparam logic [OP_W-1:0] OP_DEL_HEAD = 4'd2;
  localparam logic [OP_W-1:0] OP_DEL_TAIL = 4'd3;
  localparam logic [OP_W-1:0] OP_INS_AT   = 4'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT   = 4'd5;
  localparam logic [OP_W-1:0] OP_SEARCH   = 4'd6;
  localparam logic [OP_W-1:0] OP_FWD      = 4'd7;
  localparam logic [OP_W-1:0] OP_REV      = 4'd8;
  localparam logic [OP_W-1:0] OP_CLEAR    = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic [2:0] {
    CMD_HOLD = 3'd0,
    CMD_INS  = 3'd1,
    CMD_DEL  = 3'd2,
    CMD_ROTL = 3'd3,
    CMD_ROTR = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]            operation;
    logic signed [DATA_W-1:0]   item_value;
    logic [POS_IN_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   element_value;
    logic [POS_OUT_W-1:0]       found_position;
    logic [CNT_OUT_W-1:0]       element_count;
    logic                       last_result;
  } out_item_t;

endpackage

// ===== hw/rtl/bpl_cell.sv =====
// ----------------------------------------------------------------------------
// bpl_cell
// One list slot: holds a value, shifts or rotates with its neighbors.
// ----------------------------------------------------------------------------
module bpl_cell
  import bpl_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IDX_W = 5,
  parameter int CNT_W = 6
) (
  input  logic              clk,
  input  cell_cmd_t         cmd_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [IDX_W-1:0]  last_idx_i,
  input  logic [IDX_W-1:0]  rd_idx_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [DATA_W-1:0] item_i,
  input  logic [DATA_W-1:0] head_i,
  input  logic [DATA_W-1:0] tail_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] value_o,
  output logic [DATA_W-1:0] rd_val_o,
  output logic              match_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    case (cmd_i)
      CMD_HOLD: value_nxt = value_r;
      CMD_INS: begin
        if (MY_IDX == idx_i) begin
          value_nxt = item_i;
        end else if (MY_IDX > idx_i) begin
          value_nxt = left_i;
        end
      end
      CMD_DEL: begin
        if (MY_IDX >= idx_i) begin
          value_nxt = right_i;
        end
      end
      CMD_ROTL: value_nxt = (MY_IDX == last_idx_i) ? head_i : right_i;
      CMD_ROTR: value_nxt = (INDEX == 0) ? tail_i : left_i;
      default:  value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o  = value_r;
  assign rd_val_o = (MY_IDX == rd_idx_i) ? value_r : '0;
  // only occupied slots may hit
  assign match_o  = (MY_CNT < count_i) && (value_r == item_i);

endmodule

// ===== hw/rtl/bounded_positional_list.sv =====
// ----------------------------------------------------------------------------
// bounded_positional_list
// An insert, delete, clear or error answer is registered in EXEC after accept;
// a search passes EXEC and SRCH (the cells compare at once, a priority encode
// follows); a traversal passes EXEC, then gives one element per cycle in TRAV
// while the output is free, as the chain rotates. No new item is taken until
// the last answer is registered. Reset clears count and handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_positional_list
  import bpl_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Control sequencer: one item at a time.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for an item
    S_EXEC = 4'b0010,  // decode, shift the cells, answer
    S_SRCH = 4'b0100,  // encode registered match flags
    S_TRAV = 4'b1000   // one element per cycle while the output is free and the chain rotates
  } state_t;

  state_t                 state_r, state_nxt;
  logic [OP_W-1:0]        op_r;
  logic [DATA_W-1:0]      item_r;
  logic [POS_IN_W-1:0]    pos_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       trav_k_r, trav_k_nxt;
  logic [CAPACITY-1:0]    match_r;
  out_item_t              out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Cell chain wiring
  cell_cmd_t              cmd;
  logic [IDX_W-1:0]       cell_idx;
  logic [IDX_W-1:0]       last_idx;
  logic [IDX_W-1:0]       rd_idx;
  logic [DATA_W-1:0]      cell_val [CAPACITY];
  logic [DATA_W-1:0]      cell_rd  [CAPACITY];
  logic [CAPACITY-1:0]    cell_match;
  logic [DATA_W-1:0]      rd_val;

  // Decode helpers
  logic                   out_free;
  logic                   is_empty, is_full, is_fwd;
  logic [8:0]             pos9, n9;
  logic [IDX_W-1:0]       pos_idx;
  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic                   trav_last;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CNT_FULL);
  assign is_fwd    = (op_r == OP_FWD);
  assign pos9      = 9'(pos_r);
  assign n9        = 9'(count_r);
  assign pos_idx   = IDX_W'(pos_r - 8'd1);
  assign last_idx  = IDX_W'(count_r - CNT_ONE);
  assign trav_last = ((trav_k_r + CNT_ONE) == count_r);

  // Read port: delete index in EXEC, head or tail while traversing.
  assign rd_idx = (state_r == S_TRAV) ? (is_fwd ? '0 : last_idx) : cell_idx;

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_val = rd_val | cell_rd[i];
    end
  end

  // First hit wins: scan from the top so the lowest index stays.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Main decode
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    trav_k_nxt    = trav_k_r;
    cmd           = CMD_HOLD;
    cell_idx      = '0;
    out_nxt       = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        // insert or delete index; deletes need it early for the read port
        case (op_r)
          OP_DEL_TAIL: cell_idx = last_idx;
          OP_DEL_AT:   cell_idx = pos_idx;
          OP_INS_TAIL: cell_idx = IDX_W'(count_r);
          OP_INS_AT:   cell_idx = pos_idx;
          default:     cell_idx = '0;
        endcase

        if (out_free) begin
          out_nxt.status         = ST_OK;
          out_nxt.element_value  = '0;
          out_nxt.found_position = '0;
          out_nxt.last_result    = 1'b1;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;

          case (op_r)
            OP_INS_HEAD, OP_INS_TAIL: begin
              if (is_full) begin
                out_nxt.status = ST_FULL;
              end else begin
                cmd       = CMD_INS;
                count_nxt = count_r + CNT_ONE;
              end
            end
            OP_DEL_HEAD, OP_DEL_TAIL: begin
              if (is_empty) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                cmd                   = CMD_DEL;
                count_nxt             = count_r - CNT_ONE;
                out_nxt.element_value = rd_val;
              end
            end
            OP_INS_AT: begin
              if (pos9 == '0 || pos9 > n9 + 9'd1) begin
                out_nxt.status = ST_RANGE;
              end else if (is_full) begin
                out_nxt.status = ST_FULL;
              end else begin
                cmd       = CMD_INS;
                count_nxt = count_r + CNT_ONE;
              end
            end
            OP_DEL_AT: begin
              if (is_empty) begin
                out_nxt.status = ST_EMPTY;
              end else if (pos9 == '0 || pos9 > n9) begin
                out_nxt.status = ST_RANGE;
              end else begin
                cmd                   = CMD_DEL;
                count_nxt             = count_r - CNT_ONE;
                out_nxt.element_value = rd_val;
              end
            end
            OP_SEARCH: begin
              if (is_empty) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
                state_nxt     = S_SRCH;
              end
            end
            OP_FWD, OP_REV: begin
              if (is_empty) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
                trav_k_nxt    = '0;
                state_nxt     = S_TRAV;
              end
            end
            OP_CLEAR: count_nxt = '0;
            default: ;  // unused codes: list untouched, plain ok
          endcase
          out_nxt.element_count = CNT_OUT_W'(count_nxt);
        end
      end

      S_SRCH: begin
        if (out_free) begin
          out_nxt.status         = hit ? ST_OK : ST_NOTFOUND;
          out_nxt.element_value  = hit ? item_r : '0;
          out_nxt.found_position = hit ? POS_OUT_W'(CNT_W'(hit_idx) + CNT_ONE) : '0;
          out_nxt.element_count  = CNT_OUT_W'(count_r);
          out_nxt.last_result    = 1'b1;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end

      S_TRAV: begin
        if (out_free) begin
          // head leaves at cell 0 (rotate left) or tail at cell n-1 (rotate right);
          // after n steps the chain is back in order
          cmd                    = is_fwd ? CMD_ROTL : CMD_ROTR;
          out_nxt.status         = ST_OK;
          out_nxt.element_value  = rd_val;
          out_nxt.found_position = is_fwd ? POS_OUT_W'(trav_k_r + CNT_ONE)
                                          : POS_OUT_W'(count_r - trav_k_r);
          out_nxt.element_count  = CNT_OUT_W'(count_r);
          out_nxt.last_result    = trav_last;
          out_valid_nxt          = 1'b1;
          trav_k_nxt             = trav_k_r + CNT_ONE;
          if (trav_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    bpl_cell #(
      .INDEX (g),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd_i      (cmd),
      .idx_i      (cell_idx),
      .last_idx_i (last_idx),
      .rd_idx_i   (rd_idx),
      .count_i    (count_r),
      .item_i     (item_r),
      .head_i     (cell_val[0]),
      .tail_i     (rd_val),
      .left_i     (cell_val[(g == 0) ? 0 : g - 1]),
      .right_i    (cell_val[(g == CAPACITY - 1) ? g : g + 1]),
      .value_o    (cell_val[g]),
      .rd_val_o   (cell_rd[g]),
      .match_o    (cell_match[g])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      trav_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      trav_k_r    <= trav_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_item.operation;
      item_r <= in_item.item_value;
      pos_r  <= in_item.position;
    end
    if (state_r == S_EXEC) begin
      match_r <= cell_match;
    end
    out_r <= out_nxt;
  end

  `ASSERT_IMPLIES(a_count_bound, 1'b1, count_r <= CNT_FULL, "count above capacity")
  `ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_r == S_EXEC, "accept without execute")
  `ASSERT_NEXT(a_count_stable, state_r != S_EXEC, $stable(count_r), "count moved outside execute")
  `ASSERT_IMPLIES(a_trav_range, state_r == S_TRAV, trav_k_r < count_r, "traversal ran past the tail")

endmodule

// ===== dv/bpl_checker.sv =====
// ----------------------------------------------------------------------------
// bpl_checker
// Watches both channels of the bounded positional list. It keeps a shadow copy
// of the list, works out the answers that each accepted item should produce,
// and compares them in order with the answers that leave the block.
// ----------------------------------------------------------------------------
module bpl_checker
  import bpl_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        mismatches,
  output int        answers_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHOWN_MAX = 10;

  logic signed [DATA_W-1:0] shadow_list[$];
  out_item_t                answers_due[$];
  out_item_t                oldest;

  // Count field is the size after the operation, kept to its low bits.
  function automatic out_item_t make_answer(logic [STATUS_W-1:0] st,
                                            logic signed [DATA_W-1:0] val,
                                            int pos, bit last);
    out_item_t r;
    int        cnt;
    cnt = shadow_list.size();
    r.status         = st;
    r.element_value  = val;
    r.found_position = pos[POS_OUT_W-1:0];
    r.element_count  = cnt[CNT_OUT_W-1:0];
    r.last_result    = last;
    return r;
  endfunction

  task automatic apply_list_op(input in_item_t it);
    int                       n;
    int                       p;
    int                       idx;
    bit                       hit;
    logic signed [DATA_W-1:0] taken;
    n   = shadow_list.size();
    p   = int'(it.position);
    hit = 1'b0;
    case (it.operation)
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (n >= CAPACITY) begin
          answers_due.push_back(make_answer(ST_FULL, '0, 0, 1'b1));
        end else begin
          if (it.operation == OP_INS_HEAD) shadow_list.push_front(it.item_value);
          else shadow_list.push_back(it.item_value);
          answers_due.push_back(make_answer(ST_OK, '0, 0, 1'b1));
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL: begin
        if (n == 0) begin
          answers_due.push_back(make_answer(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          if (it.operation == OP_DEL_HEAD) taken = shadow_list.pop_front();
          else taken = shadow_list.pop_back();
          answers_due.push_back(make_answer(ST_OK, taken, 0, 1'b1));
        end
      end
      OP_INS_AT: begin
        // range check wins over the full check
        if (p < 1 || p > n + 1) begin
          answers_due.push_back(make_answer(ST_RANGE, '0, 0, 1'b1));
        end else if (n >= CAPACITY) begin
          answers_due.push_back(make_answer(ST_FULL, '0, 0, 1'b1));
        end else begin
          shadow_list.insert(p - 1, it.item_value);
          answers_due.push_back(make_answer(ST_OK, '0, 0, 1'b1));
        end
      end
      OP_DEL_AT: begin
        if (n == 0) begin
          answers_due.push_back(make_answer(ST_EMPTY, '0, 0, 1'b1));
        end else if (p < 1 || p > n) begin
          answers_due.push_back(make_answer(ST_RANGE, '0, 0, 1'b1));
        end else begin
          taken = shadow_list[p - 1];
          shadow_list.delete(p - 1);
          answers_due.push_back(make_answer(ST_OK, taken, 0, 1'b1));
        end
      end
      OP_SEARCH: begin
        if (n == 0) begin
          answers_due.push_back(make_answer(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i < n && !hit; i++) begin
            if (shadow_list[i] == it.item_value) begin
              hit = 1'b1;
              answers_due.push_back(make_answer(ST_OK, it.item_value, i + 1, 1'b1));
            end
          end
          if (!hit) answers_due.push_back(make_answer(ST_NOTFOUND, '0, 0, 1'b1));
        end
      end
      OP_FWD, OP_REV: begin
        if (n == 0) begin
          answers_due.push_back(make_answer(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++) begin
            idx = (it.operation == OP_FWD) ? i : n - 1 - i;
            answers_due.push_back(make_answer(ST_OK, shadow_list[idx], idx + 1,
                                              i == n - 1));
          end
        end
      end
      OP_CLEAR: begin
        shadow_list.delete();
        answers_due.push_back(make_answer(ST_OK, '0, 0, 1'b1));
      end
      default: begin
        answers_due.push_back(make_answer(ST_OK, '0, 0, 1'b1));
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input out_item_t want);
    mismatches++;
    if (mismatches <= SHOWN_MAX) begin
      $display("%0t bpl_checker %s: want st=%0d val=%0d pos=%0d cnt=%0d last=%0b",
               $realtime, what, want.status, want.element_value,
               want.found_position, want.element_count, want.last_result);
      $display("%0t bpl_checker %s:  got st=%0d val=%0d pos=%0d cnt=%0d last=%0b",
               $realtime, what, out_item.status, out_item.element_value,
               out_item.found_position, out_item.element_count, out_item.last_result);
    end
  endtask

  // Answers are registered in EXEC or later, after their item is taken, so an
  // answer seen on this edge never belongs to an item taken on the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_list.delete();
      answers_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          note_mismatch("unexpected answer", '0);
        end else begin
          oldest = answers_due.pop_front();
          if (out_item.status !== oldest.status ||
              out_item.element_value !== oldest.element_value ||
              out_item.found_position !== oldest.found_position ||
              out_item.element_count !== oldest.element_count ||
              out_item.last_result !== oldest.last_result)
            note_mismatch("field mismatch", oldest);
        end
      end
      if (in_valid && in_ready) apply_list_op(in_item);
    end
    answers_outstanding = answers_due.size();
  end

endmodule

// ===== dv/tb_bounded_positional_list.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_positional_list
// Drives list operations into the block and gives the verdict. A directed
// opening hits empty, range and unused-code cases, a fill segment drives the
// list to full, and a weighted random mix follows. Checking is done by the
// bpl_checker instance that sits beside the block.
// ----------------------------------------------------------------------------
module tb_bounded_positional_list
  import bpl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY       = 32;
  localparam int MIXED_ITEMS    = 115;
  localparam int QUIET_TAIL     = 30;   // last items of the run: no idling at all
  localparam int SQUEEZE_AT     = 20;   // mixed-phase item where the long hold-off starts
  localparam int SQUEEZE_CYCLES = 150;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_NS     = 4_000_000;

  // Codes 10..15 are not operations; the block answers ok and leaves the list alone.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd10;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int mismatches;
  int answers_outstanding;

  // Knobs for the sender and the receiver; sender_calm steers the sender only.
  bit tail_quiet;
  bit sender_calm;
  bit squeeze_req;
  bit squeeze_done;

  bounded_positional_list #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  bpl_checker #(
    .CAPACITY(CAPACITY)
  ) u_list_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_item            (in_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_item           (out_item),
    .mismatches         (mismatches),
    .answers_outstanding(answers_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: covers the slowest legal run several times over.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_bounded_positional_list: done, errors");
    $finish;
  end

  // Half the values come from a small pool so searches hit and duplicates
  // show up; the rest are full-width random so every data bit toggles.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      5:       return 7;
      6:       return -100;
      7:       return 100;
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions near the live range; sometimes the full 8-bit field.
  function automatic logic [POS_IN_W-1:0] pick_position();
    if ($urandom_range(0, 4) != 0) return POS_IN_W'($urandom_range(0, CAPACITY + 2));
    return POS_IN_W'($urandom_range(0, 255));
  endfunction

  // Inserts outweigh deletes, so the list drifts toward full and churns there.
  function automatic logic [OP_W-1:0] pick_operation();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return OP_INS_TAIL;
    if (r < 27) return OP_INS_HEAD;
    if (r < 41) return OP_INS_AT;
    if (r < 49) return OP_DEL_HEAD;
    if (r < 56) return OP_DEL_TAIL;
    if (r < 66) return OP_DEL_AT;
    if (r < 79) return OP_SEARCH;
    if (r < 85) return OP_FWD;
    if (r < 90) return OP_REV;
    if (r < 92) return OP_CLEAR;
    if (r < 96) return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    return OP_INS_TAIL;
  endfunction

  // Offer one item: maybe an idle burst first, then hold valid until taken.
  // Valid is only lowered when a gap is wanted, so back-to-back items keep it
  // high with a single assignment per step.
  task automatic offer_item(input logic [OP_W-1:0] op,
                            input logic signed [DATA_W-1:0] val,
                            input logic [POS_IN_W-1:0] pos);
    in_item_t it;
    int       gap;
    it.operation  = op;
    it.item_value = val;
    it.position   = pos;
    gap = 0;
    if (!tail_quiet && !sender_calm && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 10);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: random stall bursts, calm stretches, one long hold-off on
  // request, and a steady ready once the quiet tail starts.
  initial begin
    int stall;
    int beat;
    beat = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      beat++;
      if (squeeze_req && !squeeze_done) begin
        // long hold-off, counted here: the block backs up and stalls its input
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
        squeeze_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!tail_quiet && (beat / 50) % 3 != 2 && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    tail_quiet   = 1'b0;
    sender_calm  = 1'b0;
    squeeze_req  = 1'b0;
    squeeze_done = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    rst_n        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // -- directed: empty list first, then a short list with edge values --
    offer_item(OP_CLEAR, '0, '0);              // clear on an empty list
    offer_item(OP_DEL_HEAD, '0, '0);           // empty
    offer_item(OP_DEL_TAIL, '0, '0);           // empty
    offer_item(OP_DEL_AT, '0, 8'd0);           // empty check comes before range
    offer_item(OP_SEARCH, '0, '0);             // empty
    offer_item(OP_FWD, '0, '0);                // one empty answer
    offer_item(OP_REV, '0, '0);                // one empty answer
    offer_item(OP_INS_AT, 5, 8'd0);            // position zero: range
    offer_item(OP_INS_AT, 5, 8'd2);            // past count+1: range
    offer_item(OP_INS_AT, VAL_MIN, 8'd1);      // count+1 is a legal spot
    offer_item(OP_INS_HEAD, VAL_MAX, '1);
    offer_item(OP_INS_TAIL, -1, '0);
    offer_item(OP_INS_TAIL, '0, '0);
    offer_item(OP_INS_AT, 9, 8'd255);          // top of the position field
    offer_item(OP_SEARCH, -1, '0);             // hit at position 3
    offer_item(OP_SEARCH, 12345, '0);          // miss
    offer_item(OP_FWD, '0, '0);
    offer_item(OP_REV, '0, '0);                // positions reported tail to head
    offer_item(OP_DEL_AT, '0, 8'd0);           // range on a non-empty list
    offer_item(OP_DEL_AT, '0, 8'd5);           // one past count: range
    offer_item(OP_DEL_AT, '0, 8'd2);
    offer_item(OP_UNUSED_HI, VAL_MAX, '1);     // unused code: ok, list untouched
    offer_item(OP_DEL_HEAD, '0, '0);
    offer_item(OP_DEL_TAIL, '0, '0);
    offer_item(OP_CLEAR, '0, '0);              // clear on a non-empty list

    // -- fill to capacity, then poke the full-list cases --
    for (int i = 0; i < CAPACITY; i++)
      offer_item(OP_INS_TAIL, pick_value(), pick_position());
    offer_item(OP_INS_HEAD, pick_value(), pick_position());      // full
    offer_item(OP_INS_AT, pick_value(), 8'd1);                   // full
    offer_item(OP_INS_AT, pick_value(), POS_IN_W'(CAPACITY + 2)); // range beats full
    offer_item(OP_INS_AT, pick_value(), POS_IN_W'(CAPACITY + 1)); // in range, full
    offer_item(OP_FWD, '0, pick_position());                     // longest traversals
    offer_item(OP_REV, '0, pick_position());
    offer_item(OP_SEARCH, pick_value(), pick_position());
    offer_item(OP_DEL_AT, '0, POS_IN_W'(CAPACITY));              // delete the tail slot

    // -- weighted random mix --
    for (int k = 0; k < MIXED_ITEMS; k++) begin
      if (k == SQUEEZE_AT) squeeze_req = 1'b1;
      if (k >= MIXED_ITEMS - QUIET_TAIL) tail_quiet = 1'b1;
      sender_calm = ((k / 30) % 4 == 3);
      offer_item(pick_operation(), pick_value(), pick_position());
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Every item answers at least once, so an empty answer queue means the
    // block is done; the extra cycles catch any stray answer.
    wait (answers_outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && answers_outstanding == 0)
      $display("tb_bounded_positional_list: done, clean");
    else
      $display("tb_bounded_positional_list: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bpl_pkg.sv
hw/rtl/bpl_cell.sv
hw/rtl/bounded_positional_list.sv
dv/bpl_checker.sv
dv/tb_bounded_positional_list.sv
